// File: rtl/core/pfba_pkg.sv
package pfba_pkg;

    localparam int FRAME_W  = 12;
    localparam int WORD_W   = 32;
    localparam int BIT_W    = 5;
    localparam int CFG_W    = 8;
    localparam int STATUS_W = 2;

    localparam logic [CFG_W-1:0]  WORDS_IN_USE_RST = 8'd128;
    localparam logic [WORD_W-1:0] FULL_WORD        = 32'hFFFF_FFFF;

    localparam logic ACT_ALLOC = 1'b0;
    localparam logic ACT_FREE  = 1'b1;

    localparam logic [STATUS_W-1:0] ST_DONE      = 2'd0;
    localparam logic [STATUS_W-1:0] ST_NO_CHANGE = 2'd1;
    localparam logic [STATUS_W-1:0] ST_NO_FREE   = 2'd2;

    typedef enum logic [2:0] {
        S_CLEAR,
        S_IDLE,
        S_SCAN,
        S_FREE_WR,
        S_DONE
    } pfba_state_t;

    typedef struct packed {
        logic               action;
        logic [FRAME_W-1:0] page_frame;
        logic               kernel_only;
        logic               write_allowed;
    } pfba_req_t;

    typedef struct packed {
        logic [FRAME_W-1:0]  new_frame;
        logic                present;
        logic                writable;
        logic                user_mode;
        logic [STATUS_W-1:0] status;
    } pfba_rsp_t;

endpackage

// File: rtl/core/page_frame_bitmap_allocator.sv
// Paths from accept to m_valid: no-change, unscanned no-free and out-of-range frees go
//   straight to S_DONE, a free that writes the bitmap passes S_FREE_WR first, and a claim
//   scans words in S_SCAN until one has a clear bit or limit is reached. One request in flight:
//   s_ready returns the cycle after the result loads.
// Reset: synchronous, active low; afterwards a clearing pass zeroes every bitmap word before
//   s_ready rises. words_in_use resets to 128.
module page_frame_bitmap_allocator #(
    parameter int MAX_WORDS = 128
) (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     cfg_we,
    input  logic [pfba_pkg::CFG_W-1:0] cfg_wdata,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  pfba_pkg::pfba_req_t      s_req,
    output logic                     m_valid,
    input  logic                     m_ready,
    output pfba_pkg::pfba_rsp_t      m_rsp
);

    localparam int AW  = (MAX_WORDS > 1) ? $clog2(MAX_WORDS) : 1;
    localparam int CW  = $clog2(MAX_WORDS + 1);
    localparam int WW  = pfba_pkg::WORD_W;
    localparam int BW  = pfba_pkg::BIT_W;
    localparam int FRW = pfba_pkg::FRAME_W;

    pfba_pkg::pfba_state_t state_reg, state_next;
    pfba_pkg::pfba_req_t   req_reg, req_next;
    pfba_pkg::pfba_rsp_t   rsp_reg, rsp_next;
    pfba_pkg::pfba_rsp_t   m_rsp_reg;
    logic                  m_valid_reg;
    logic [pfba_pkg::CFG_W-1:0] words_reg;
    logic [CW-1:0]         idx_reg, idx_next;
    logic [CW-1:0]         idx_inc;
    logic [CW-1:0]         limit;

    logic                  ram_we, ram_re;
    logic [AW-1:0]         ram_waddr, ram_raddr;
    logic [WW-1:0]         ram_wdata, ram_rdata;

    logic                  accept, m_free, m_load;
    logic                  word_full, last_word, in_range;
    logic [WW-1:0]         inv_word, low_zero, free_mask;
    logic [BW-1:0]         zero_bit;

    pfba_ram #(
        .WIDTH (pfba_pkg::WORD_W),
        .DEPTH (MAX_WORDS)
    ) u_bitmap (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    assign s_ready = (state_reg == pfba_pkg::S_IDLE);
    assign accept  = s_valid && s_ready;
    assign m_valid = m_valid_reg;
    assign m_rsp   = m_rsp_reg;
    assign m_free  = !m_valid_reg || m_ready;

    assign limit     = (32'(words_reg) > MAX_WORDS) ? CW'(MAX_WORDS) : CW'(words_reg);
    assign idx_inc   = idx_reg + CW'(1);
    assign last_word = (idx_inc == limit);
    assign word_full = (ram_rdata == pfba_pkg::FULL_WORD);
    assign in_range  = (32'(s_req.page_frame[FRW-1:BW]) < MAX_WORDS);

    assign inv_word  = ~ram_rdata;
    assign low_zero  = inv_word & (~inv_word + WW'(1));
    assign free_mask = WW'(1) << req_reg.page_frame[BW-1:0];

    always_comb begin
        zero_bit = '0;
        for (int i = 0; i < WW; i++) begin
            if (low_zero[i]) begin
                zero_bit = zero_bit | BW'(i);
            end
        end
    end

    // next state
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            pfba_pkg::S_CLEAR: begin
                if (idx_reg == CW'(MAX_WORDS - 1)) begin
                    state_next = pfba_pkg::S_IDLE;
                end
            end
            pfba_pkg::S_IDLE: begin
                if (accept) begin
                    priority if (s_req.action == pfba_pkg::ACT_ALLOC &&
                                 s_req.page_frame == '0 && limit != '0) begin
                        state_next = pfba_pkg::S_SCAN;
                    end else if (s_req.action == pfba_pkg::ACT_FREE &&
                                 s_req.page_frame != '0 && in_range) begin
                        state_next = pfba_pkg::S_FREE_WR;
                    end else begin
                        state_next = pfba_pkg::S_DONE;
                    end
                end
            end
            pfba_pkg::S_SCAN: begin
                if (!word_full || last_word) begin
                    state_next = pfba_pkg::S_DONE;
                end
            end
            pfba_pkg::S_FREE_WR: begin
                state_next = pfba_pkg::S_DONE;
            end
            pfba_pkg::S_DONE: begin
                if (m_free) begin
                    state_next = pfba_pkg::S_IDLE;
                end
            end
            default: begin
                state_next = pfba_pkg::S_CLEAR;
            end
        endcase
    end

    // datapath and RAM control
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = idx_reg[AW-1:0];
        ram_wdata = '0;
        ram_re    = 1'b0;
        ram_raddr = '0;
        idx_next  = idx_reg;
        req_next  = req_reg;
        rsp_next  = rsp_reg;
        m_load    = 1'b0;
        unique case (state_reg)
            pfba_pkg::S_CLEAR: begin
                ram_we   = 1'b1;
                idx_next = idx_inc;
            end
            pfba_pkg::S_IDLE: begin
                if (accept) begin
                    req_next = s_req;
                    idx_next = '0;
                    ram_re   = 1'b1;
                    rsp_next = '0;
                    if (s_req.action == pfba_pkg::ACT_ALLOC) begin
                        ram_raddr = '0;
                        priority if (s_req.page_frame != '0) begin
                            rsp_next.new_frame = s_req.page_frame;
                            rsp_next.status    = pfba_pkg::ST_NO_CHANGE;
                        end else begin
                            rsp_next.status    = pfba_pkg::ST_NO_FREE;
                        end
                    end else begin
                        ram_raddr = AW'(s_req.page_frame[FRW-1:BW]);
                        rsp_next.status = (s_req.page_frame == '0) ?
                                          pfba_pkg::ST_NO_CHANGE : pfba_pkg::ST_DONE;
                    end
                end
            end
            pfba_pkg::S_SCAN: begin
                if (word_full) begin
                    if (!last_word) begin
                        idx_next  = idx_inc;
                        ram_re    = 1'b1;
                        ram_raddr = idx_inc[AW-1:0];
                    end
                end else begin
                    ram_we             = 1'b1;
                    ram_wdata          = ram_rdata | low_zero;
                    rsp_next.new_frame = FRW'({idx_reg[AW-1:0], zero_bit});
                    rsp_next.present   = 1'b1;
                    rsp_next.writable  = req_reg.write_allowed;
                    rsp_next.user_mode = ~req_reg.kernel_only;
                    rsp_next.status    = pfba_pkg::ST_DONE;
                end
            end
            pfba_pkg::S_FREE_WR: begin
                ram_we    = 1'b1;
                ram_waddr = AW'(req_reg.page_frame[FRW-1:BW]);
                ram_wdata = ram_rdata & ~free_mask;
            end
            pfba_pkg::S_DONE: begin
                m_load = m_free;
            end
            default: begin
                idx_next = '0;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= pfba_pkg::S_CLEAR;
            idx_reg     <= '0;
            words_reg   <= pfba_pkg::WORDS_IN_USE_RST;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            idx_reg   <= idx_next;
            if (cfg_we) begin
                words_reg <= cfg_wdata;
            end
            if (m_load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        req_reg <= req_next;
        rsp_reg <= rsp_next;
        if (m_load) begin
            m_rsp_reg <= rsp_reg;
        end
    end

endmodule

// File: rtl/core/pfba_ram.sv
module pfba_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 128
) (
    input  logic                             aclk,
    input  logic                             we,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] waddr,
    input  logic [WIDTH-1:0]                 wdata,
    input  logic                             re,
    input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] raddr,
    output logic [WIDTH-1:0]                 rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata <= mem[raddr];
        end
    end

endmodule

// File: rtl/core/pfba_checker.sv
module pfba_checker (
    input logic                aclk,
    input logic                aresetn,
    input logic                s_valid,
    input logic                s_ready,
    input logic                m_valid,
    input logic                m_ready,
    input pfba_pkg::pfba_rsp_t m_rsp
);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_rsp))
        else $error("result dropped or changed while stalled");

    a_one_at_a_time: assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("second request taken while one is in flight");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_rsp.status == pfba_pkg::ST_DONE ||
                     m_rsp.status == pfba_pkg::ST_NO_CHANGE ||
                     m_rsp.status == pfba_pkg::ST_NO_FREE))
        else $error("undefined status");

    a_flags_only_on_alloc: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_rsp.present || m_rsp.writable || m_rsp.user_mode)
        |-> m_rsp.present && m_rsp.status == pfba_pkg::ST_DONE)
        else $error("entry flags without an allocation");

endmodule

bind page_frame_bitmap_allocator pfba_checker u_pfba_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_rsp   (m_rsp)
);

// File: test/testbench.sv
`timescale 1ns / 1ps

module testbench;

    localparam int MAX_WORDS   = 128;
    localparam int HOLD_CYCLES = 300;
    localparam int FRAME_W     = pfba_pkg::FRAME_W;
    localparam int WORD_W      = pfba_pkg::WORD_W;
    localparam int BIT_W       = pfba_pkg::BIT_W;
    localparam int CFG_W       = pfba_pkg::CFG_W;

    logic      aclk;
    logic      aresetn;
    logic      cfg_we;
    logic [CFG_W-1:0] cfg_wdata;
    logic      s_valid;
    logic      s_ready;
    pfba_pkg::pfba_req_t s_req;
    logic      m_valid;
    logic      m_ready;
    pfba_pkg::pfba_rsp_t m_rsp;

    page_frame_bitmap_allocator #(
        .MAX_WORDS (MAX_WORDS)
    ) dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_req     (s_req),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_rsp     (m_rsp)
    );

    logic [WORD_W-1:0]  frame_in_use [MAX_WORDS];
    int unsigned        words_searched;
    pfba_pkg::pfba_rsp_t pending_rsp [$];
    logic [FRAME_W-1:0] held_frames [$];
    int                 mismatches = 0;
    bit                 calm = 1'b0;
    bit                 hold_rsp = 1'b0;

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #12_000_000;
        $display("testbench: done, errors");
        $finish;
    end

    // first-fit claim or release against the shadow bitmap
    function automatic pfba_pkg::pfba_rsp_t claim_or_release(input pfba_pkg::pfba_req_t req);
        pfba_pkg::pfba_rsp_t rsp;
        int unsigned limit;
        bit          found;
        rsp = '0;
        if (req.action == pfba_pkg::ACT_ALLOC) begin
            if (req.page_frame != '0) begin
                rsp.new_frame = req.page_frame;
                rsp.status    = pfba_pkg::ST_NO_CHANGE;
            end else begin
                limit = (words_searched > MAX_WORDS) ? MAX_WORDS : words_searched;
                found = 1'b0;
                for (int unsigned w = 0; w < limit && !found; w++) begin
                    for (int unsigned b = 0; b < WORD_W && !found; b++) begin
                        if (!frame_in_use[w][b]) begin
                            found              = 1'b1;
                            frame_in_use[w][b] = 1'b1;
                            rsp.new_frame      = FRAME_W'(w * WORD_W + b);
                            rsp.present        = 1'b1;
                            rsp.writable       = req.write_allowed;
                            rsp.user_mode      = ~req.kernel_only;
                            rsp.status         = pfba_pkg::ST_DONE;
                        end
                    end
                end
                if (!found)
                    rsp.status = pfba_pkg::ST_NO_FREE;
            end
        end else begin
            if (req.page_frame == '0) begin
                rsp.status = pfba_pkg::ST_NO_CHANGE;
            end else begin
                frame_in_use[req.page_frame[FRAME_W-1:BIT_W]][req.page_frame[BIT_W-1:0]] = 1'b0;
                rsp.status = pfba_pkg::ST_DONE;
            end
        end
        return rsp;
    endfunction

    task automatic send_request(input logic act, input logic [FRAME_W-1:0] frame,
                                input logic kern, input logic wr);
        pfba_pkg::pfba_req_t req;
        pfba_pkg::pfba_rsp_t want;
        int        gap;
        req.action        = act;
        req.page_frame    = frame;
        req.kernel_only   = kern;
        req.write_allowed = wr;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 10);
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_req   <= req;
        s_valid <= 1'b1;
        do @(posedge aclk); while (!s_ready);
        want = claim_or_release(req);
        pending_rsp.push_back(want);
        if (act == pfba_pkg::ACT_ALLOC && want.status == pfba_pkg::ST_DONE &&
            want.new_frame != '0)
            held_frames.push_back(want.new_frame);
        if (act == pfba_pkg::ACT_FREE) begin
            for (int i = 0; i < held_frames.size(); i++) begin
                if (held_frames[i] == frame) begin
                    held_frames.delete(i);
                    break;
                end
            end
        end
    endtask

    task automatic wait_drain();
        s_valid <= 1'b0;
        while (pending_rsp.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic set_words_in_use(input logic [CFG_W-1:0] n);
        wait_drain();
        cfg_wdata <= n;
        cfg_we    <= 1'b1;
        @(posedge aclk);
        cfg_we    <= 1'b0;
        words_searched = 32'(n);
    endtask

    task automatic test_first_fit();
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b0, 1'b1);   // frame 0 is claimable
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b1, 1'b0);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b1, 1'b1);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b0, 1'b0);
        send_request(pfba_pkg::ACT_ALLOC, 12'hFFF, 1'b0, 1'b1);   // already holds a frame
        send_request(pfba_pkg::ACT_ALLOC, 12'h001, 1'b1, 1'b1);
        send_request(pfba_pkg::ACT_FREE,  12'd0,   1'b1, 1'b1);   // nothing to free
        send_request(pfba_pkg::ACT_FREE,  12'd1,   1'b0, 1'b0);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b0, 1'b1);   // reuses the lowest hole
        send_request(pfba_pkg::ACT_FREE,  12'hFFF, 1'b1, 1'b0);   // bit already clear
        send_request(pfba_pkg::ACT_FREE,  12'h800, 1'b0, 1'b1);
        send_request(pfba_pkg::ACT_FREE,  12'd3,   1'b1, 1'b1);
        wait_drain();
    endtask

    task automatic test_words_limits();
        set_words_in_use(8'd0);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b1, 1'b1);   // nothing searched
        send_request(pfba_pkg::ACT_ALLOC, 12'h555, 1'b0, 1'b0);
        send_request(pfba_pkg::ACT_FREE,  12'd2,   1'b0, 1'b0);
        set_words_in_use(8'd255);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b0, 1'b0);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b1, 1'b0);
        set_words_in_use(8'd128);
        send_request(pfba_pkg::ACT_ALLOC, 12'd0,   1'b0, 1'b1);
        wait_drain();
    endtask

    task automatic test_exhaustion(input logic [CFG_W-1:0] words, input int count);
        int idx;
        set_words_in_use(words);
        repeat (count) begin
            if (held_frames.size() != 0 && $urandom_range(0, 99) < 25) begin
                idx = $urandom_range(0, held_frames.size() - 1);
                send_request(pfba_pkg::ACT_FREE, held_frames[idx], 1'($urandom),
                             1'($urandom));
            end else begin
                send_request(pfba_pkg::ACT_ALLOC, 12'd0, 1'($urandom), 1'($urandom));
            end
        end
        wait_drain();
    endtask

    task automatic test_backpressure();
        hold_rsp = 1'b1;
        repeat (10)
            send_request(pfba_pkg::ACT_ALLOC, 12'd0, 1'($urandom), 1'($urandom));
        wait (!hold_rsp);
        wait_drain();
    endtask

    task automatic test_random_mix(input logic [CFG_W-1:0] words, input int count);
        int unsigned pick;
        int          idx;
        set_words_in_use(words);
        repeat (count) begin
            pick = $urandom_range(0, 99);
            if (pick < 50 && held_frames.size() < 300) begin
                send_request(pfba_pkg::ACT_ALLOC, 12'd0, 1'($urandom), 1'($urandom));
            end else if (pick < 82 && held_frames.size() != 0) begin
                idx = $urandom_range(0, held_frames.size() - 1);
                send_request(pfba_pkg::ACT_FREE, held_frames[idx], 1'($urandom),
                             1'($urandom));
            end else if (pick < 90) begin
                send_request(pfba_pkg::ACT_ALLOC, FRAME_W'($urandom_range(1, 4095)),
                             1'($urandom), 1'($urandom));
            end else if (pick < 96) begin
                send_request(pfba_pkg::ACT_FREE, FRAME_W'($urandom), 1'($urandom),
                             1'($urandom));
            end else begin
                send_request(pfba_pkg::ACT_FREE, 12'd0, 1'($urandom), 1'($urandom));
            end
        end
        wait_drain();
    endtask

    initial begin
        m_ready <= 1'b0;
        forever begin
            @(posedge aclk);
            if (hold_rsp) begin
                m_ready <= 1'b0;
                for (int held = 0; held < HOLD_CYCLES; held++)
                    @(posedge aclk);
                m_ready <= 1'b1;
                hold_rsp = 1'b0;
            end else if (!calm && $urandom_range(0, 6) == 0) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 10)) @(posedge aclk);
                m_ready <= 1'b1;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    task automatic check_field(input string fname, input int unsigned want,
                               input int unsigned got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, actual %0d", $time, fname, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin : rsp_check
        pfba_pkg::pfba_rsp_t want;
        if (aresetn && m_valid && m_ready) begin
            if (pending_rsp.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %h", $time, m_rsp);
                mismatches++;
            end else begin
                want = pending_rsp.pop_front();
                check_field("new_frame", 32'(want.new_frame), 32'(m_rsp.new_frame));
                check_field("present",   32'(want.present),   32'(m_rsp.present));
                check_field("writable",  32'(want.writable),  32'(m_rsp.writable));
                check_field("user_mode", 32'(want.user_mode), 32'(m_rsp.user_mode));
                check_field("status",    32'(want.status),    32'(m_rsp.status));
            end
        end
    end

    initial begin
        aresetn   <= 1'b0;
        s_valid   <= 1'b0;
        s_req     <= '0;
        cfg_we    <= 1'b0;
        cfg_wdata <= '0;
        for (int i = 0; i < MAX_WORDS; i++)
            frame_in_use[i] = '0;
        words_searched = 32'(pfba_pkg::WORDS_IN_USE_RST);
        repeat (3) @(posedge aclk);
        aresetn <= 1'b1;

        test_first_fit();
        test_words_limits();
        test_exhaustion(8'd1, 60);
        test_exhaustion(8'd3, 100);
        test_backpressure();
        test_random_mix(8'd128, 230);
        test_random_mix(8'($urandom_range(4, 127)), 230);
        test_random_mix(8'd255, 230);
        test_random_mix(8'd8, 230);
        test_random_mix(8'($urandom_range(0, 255)), 230);
        calm = 1'b1;
        test_random_mix(8'd128, 230);

        wait_drain();
        repeat (8) @(posedge aclk);
        if (mismatches == 0 && pending_rsp.size() == 0) begin
            $display("testbench: done, clean");
        end else begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
